/* src/sfrd_pkg.sv */
// shared types, constants and decode function for the sensor frame record decoder
`timescale 1ns / 1ps
package sfrd_pkg;

  localparam int unsigned FrameBytesDefault = 64;
  localparam int unsigned StoreDepth        = 15;
  localparam int unsigned PosW              = 7;
  localparam int unsigned CntW              = 4;
  localparam int unsigned RecW              = 22;
  localparam int unsigned CfgIdxW           = 2;

  localparam logic [CfgIdxW-1:0] CFG_HEADER     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TERMINATOR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAW_CMD    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROC_CMD   = 2'd3;

  localparam logic [7:0] HEADER_RST     = 8'hff;
  localparam logic [7:0] TERMINATOR_RST = 8'hfe;
  localparam logic [7:0] RAW_CMD_RST    = 8'haa;
  localparam logic [7:0] PROC_CMD_RST   = 8'hdd;

  localparam logic [7:0] DATA_MASK = 8'h7f;
  localparam logic [7:0] ID_MASK   = 8'h1f;
  localparam logic [7:0] TOP_MASK  = 8'h60;

  // controller to datapath
  typedef struct packed {
    logic accept_en;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drain_req;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
    logic [4:0]  id;
  } rec_t;

  function automatic rec_t decode_record(input logic [23:0] first3, input logic [7:0] check);
    logic [7:0] id;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] id_top;
    rec_t       r;
    id     = first3[23:16];
    hi     = first3[15:8];
    lo     = first3[7:0];
    id_top = id & TOP_MASK;
    r.ok    = (check == ((id ^ hi ^ lo) & DATA_MASK));
    r.value = {id_top[6:5], hi[6:0], lo[6:0]};
    r.id    = id[4:0];
    return r;
  endfunction

endpackage

/* src/sfrd_if.sv */
// channel interfaces: byte input, record output, configuration write
`timescale 1ns / 1ps
interface sfrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrd_rec_if;
  logic        valid;
  logic        ready;
  logic [4:0]  sensor_id;
  logic [15:0] sensor_value;
  logic        checksum_ok;
  logic        processed_mode;
  logic        last_record;
  modport source (output valid, output sensor_id, output sensor_value, output checksum_ok,
                  output processed_mode, output last_record, input ready);
  modport sink (input valid, input sensor_id, input sensor_value, input checksum_ok,
                input processed_mode, input last_record, output ready);
endinterface

interface sfrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/sensor_frame_record_decoder_unit.sv */
// top level of the sensor frame record decoder
//
// usage: serial bytes enter on rx_i one transaction each. a header byte
// starts a frame, the next byte is the command, then 4-byte records follow
// (id, high data, low data, xor checksum). a terminator byte ends the frame;
// if the command matched the raw or processed command register, one record
// transaction per complete stored record leaves on rec_o, last_record set on
// the final one. frames that pass FRAME_BYTES or 15 records are dropped.
// cfg_i writes header, terminator, raw and processed command registers
// (index 0 to 3); cfg_i is always ready. the user must see that it is
// written only while idle; the block itself does not enforce this. the first
// record follows the terminator as the controller enters the drain state,
// then a store read loads the output register.
// throughput: one byte per cycle while parsing; after a terminator with
// stored records the input is held off while the drain state reads the
// store into the output register, one record per cycle unless the receiver
// stalls. a stalled result simply holds in the output register; the last
// result may wait while new bytes are already being taken.
// reset: config registers return to 0xff, 0xfe, 0xaa, 0xdd, the parser
// leaves any frame and the output goes empty; the record store is not cleared.
`timescale 1ns / 1ps
module sensor_frame_record_decoder_unit
  import sfrd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfrd_byte_if.sink    rx_i,
  sfrd_rec_if.source   rec_o,
  sfrd_cfg_if.sink     cfg_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  rec_t     out_rec;
  logic     in_ready;

  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  sfrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  sfrd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (rec_o.ready),
    .out_valid_o (rec_o.valid),
    .out_rec_o   (out_rec),
    .out_mode_o  (rec_o.processed_mode),
    .out_last_o  (rec_o.last_record),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign rec_o.sensor_id    = out_rec.id;
  assign rec_o.sensor_value = out_rec.value;
  assign rec_o.checksum_ok  = out_rec.ok;

endmodule

/* src/sfrd_datapath.sv */
// datapath: config registers, frame parser, record store and output register
`timescale 1ns / 1ps
module sfrd_datapath
  import sfrd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rec_t               out_rec_o,
  output logic               out_mode_o,
  output logic               out_last_o,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o
);

  logic [7:0] header_q, terminator_q, raw_cmd_q, proc_cmd_q;

  logic            capturing_q, capturing_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      fcmd_q, fcmd_d;
  logic [23:0]     partial_q, partial_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            mode_q, mode_d;
  logic            store_we;

  logic [RecW-1:0] store_q [StoreDepth];

  logic       accept;
  logic [7:0] eff_cmd;
  logic [1:0] slot;
  logic       drain_req;

  logic out_valid_q;
  rec_t out_rec_q;
  logic out_mode_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= HEADER_RST;
      terminator_q <= TERMINATOR_RST;
      raw_cmd_q    <= RAW_CMD_RST;
      proc_cmd_q   <= PROC_CMD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER:     header_q     <= cfg_data_i;
        CFG_TERMINATOR: terminator_q <= cfg_data_i;
        CFG_RAW_CMD:    raw_cmd_q    <= cfg_data_i;
        CFG_PROC_CMD:   proc_cmd_q   <= cfg_data_i;
        default:        header_q     <= header_q;
      endcase
    end
  end

  assign accept  = in_valid_i && cmd_i.accept_en;
  assign eff_cmd = (pos_q == PosW'(1)) ? rx_byte_i : fcmd_q;
  assign slot    = pos_q[1:0] - 2'd2;

  always_comb begin
    capturing_d = capturing_q;
    pos_d       = pos_q;
    fcmd_d      = fcmd_q;
    partial_d   = partial_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    mode_d      = mode_q;
    store_we    = 1'b0;
    drain_req   = 1'b0;
    if (accept) begin
      priority if (rx_byte_i == header_q) begin
        capturing_d = 1'b1;
        pos_d       = PosW'(1);
        fcmd_d      = '0;
        partial_d   = '0;
        count_d     = '0;
      end else if (!capturing_q) begin
        capturing_d = 1'b0;
      end else if (rx_byte_i == terminator_q) begin
        capturing_d = 1'b0;
        pos_d       = '0;
        fcmd_d      = eff_cmd;
        rd_ptr_d    = '0;
        // raw wins when both commands match
        if (eff_cmd == raw_cmd_q) begin
          mode_d    = 1'b0;
          drain_req = (count_q != '0);
        end else if (eff_cmd == proc_cmd_q) begin
          mode_d    = 1'b1;
          drain_req = (count_q != '0);
        end
      end else if (32'(pos_q) >= 32'(FRAME_BYTES)) begin
        capturing_d = 1'b0;
        pos_d       = '0;
      end else if (pos_q == PosW'(1)) begin
        fcmd_d = rx_byte_i;
        pos_d  = pos_q + PosW'(1);
      end else if (slot != 2'd3) begin
        partial_d = {partial_q[15:0], rx_byte_i};
        pos_d     = pos_q + PosW'(1);
      end else if (32'(count_q) >= 32'(StoreDepth)) begin
        capturing_d = 1'b0;
        pos_d       = '0;
      end else begin
        store_we  = 1'b1;
        count_d   = count_q + CntW'(1);
        partial_d = '0;
        pos_d     = pos_q + PosW'(1);
      end
    end else if (cmd_i.load) begin
      rd_ptr_d = rd_ptr_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      pos_q       <= '0;
      fcmd_q      <= '0;
      partial_q   <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      mode_q      <= 1'b0;
    end else begin
      capturing_q <= capturing_d;
      pos_q       <= pos_d;
      fcmd_q      <= fcmd_d;
      partial_q   <= partial_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      mode_q      <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= decode_record(partial_q, rx_byte_i);
    end
  end

  // output register, refilled in the same cycle it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_rec_q  <= store_q[rd_ptr_q];
      out_mode_q <= mode_q;
      out_last_q <= stat_o.rd_last;
    end
  end

  assign stat_o.drain_req = drain_req;
  assign stat_o.rd_last   = (rd_ptr_q == count_q - CntW'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign out_mode_o  = out_mode_q;
  assign out_last_o  = out_last_q;

endmodule

/* src/sfrd_ctrl.sv */
// controller: byte intake versus record drain sequencing
`timescale 1ns / 1ps
module sfrd_ctrl
  import sfrd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     in_ready_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.drain_req) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat_i.out_free && stat_i.rd_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.accept_en = (state_q == ST_IDLE);
  assign cmd_o.load      = (state_q == ST_DRAIN) && stat_i.out_free;
  assign in_ready_o      = cmd_o.accept_en;

  a_drain_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.drain_req |-> cmd_o.accept_en)
    else $error("drain requested while not taking bytes");

  a_drain_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.drain_req |=> (state_q == ST_DRAIN) && !in_ready_o)
    else $error("drain did not start after terminator");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && stat_i.rd_last |=> in_ready_o)
    else $error("intake not resumed after last record");

  a_no_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.accept_en)
    else $error("record load during byte intake");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the sensor frame record decoder: byte driver, record monitor, predictor
`timescale 1ns / 1ps
module testbench;
  import sfrd_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned FRAME_LIMIT = FrameBytesDefault;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
    logic [4:0]  id;
  } sensor_reading_t;

  typedef struct packed {
    logic [4:0]  sensor_id;
    logic [15:0] sensor_value;
    logic        checksum_ok;
    logic        processed_mode;
    logic        last_record;
  } record_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sfrd_byte_if byte_bus ();
  sfrd_rec_if  record_bus ();
  sfrd_cfg_if  cfg_bus ();

  sensor_frame_record_decoder_unit #(
    .FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (byte_bus),
    .rec_o (record_bus),
    .cfg_i (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // register shadow, shared by the stimulus and the predictor
  logic [7:0] cfg_header     = HEADER_RST;
  logic [7:0] cfg_terminator = TERMINATOR_RST;
  logic [7:0] cfg_raw        = RAW_CMD_RST;
  logic [7:0] cfg_proc       = PROC_CMD_RST;

  // predictor state
  logic            in_frame      = 1'b0;
  logic [6:0]      frame_pos     = '0;
  logic [7:0]      frame_cmd     = '0;
  logic [23:0]     partial_bytes = '0;
  sensor_reading_t readings [StoreDepth];
  logic [3:0]      reading_count = '0;

  logic [7:0]     pending_bytes[$];
  record_result_t pending_readings[$];
  record_result_t want;

  int unsigned error_count    = 0;
  int unsigned bytes_taken    = 0;
  int unsigned records_seen   = 0;
  int unsigned frames_emitted = 0;
  int unsigned frames_dropped = 0;
  int unsigned queued_count   = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 10);
  endfunction

  function automatic sensor_reading_t unpack_reading(input logic [23:0] first3,
                                                     input logic [7:0] chk);
    sensor_reading_t r;
    logic [7:0] idb;
    logic [7:0] hib;
    logic [7:0] lob;
    idb = first3[23:16];
    hib = first3[15:8];
    lob = first3[7:0];
    r.id    = idb[4:0];
    r.value = {idb[6:5], hib[6:0], lob[6:0]};
    r.ok    = (chk == ((idb ^ hib ^ lob) & DATA_MASK));
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    record_result_t res;
    if (b == cfg_header) begin
      in_frame      = 1'b1;
      frame_pos     = 7'd1;
      frame_cmd     = '0;
      partial_bytes = '0;
      reading_count = '0;
    end else if (in_frame) begin
      if (b == cfg_terminator) begin
        if (frame_pos == 7'd1) frame_cmd = b;
        in_frame  = 1'b0;
        frame_pos = '0;
        if (frame_cmd == cfg_raw || frame_cmd == cfg_proc) begin
          for (int k = 0; k < reading_count; k++) begin
            res.sensor_id      = readings[k].id;
            res.sensor_value   = readings[k].value;
            res.checksum_ok    = readings[k].ok;
            res.processed_mode = (frame_cmd != cfg_raw);
            res.last_record    = (k + 1 == reading_count);
            pending_readings.push_back(res);
          end
          if (reading_count != 0) frames_emitted++;
        end
      end else if (frame_pos >= FRAME_LIMIT) begin
        in_frame  = 1'b0;
        frame_pos = '0;
        frames_dropped++;
      end else if (frame_pos == 7'd1) begin
        frame_cmd = b;
        frame_pos++;
      end else if (((frame_pos - 7'd2) & 7'd3) != 7'd3) begin
        partial_bytes = {partial_bytes[15:0], b};
        frame_pos++;
      end else if (reading_count >= StoreDepth) begin
        in_frame  = 1'b0;
        frame_pos = '0;
        frames_dropped++;
      end else begin
        readings[reading_count] = unpack_reading(partial_bytes, b);
        reading_count++;
        partial_bytes = '0;
        frame_pos++;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_bus.valid <= 1'b0;
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        decode_byte(byte_bus.rx_byte);
        bytes_taken++;
      end
      if (!byte_bus.valid || byte_bus.ready) begin
        if (pending_bytes.size() > 0 && !take_break()) begin
          byte_bus.valid   <= 1'b1;
          byte_bus.rx_byte <= pending_bytes.pop_front();
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  // record monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      record_bus.ready <= 1'b0;
    end else begin
      if (record_bus.valid && record_bus.ready) begin
        records_seen++;
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual id %0h value %0h",
                   $time, record_bus.sensor_id, record_bus.sensor_value);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          check_field("sensor_id", want.sensor_id, record_bus.sensor_id);
          check_field("sensor_value", want.sensor_value, record_bus.sensor_value);
          check_field("checksum_ok", want.checksum_ok, record_bus.checksum_ok);
          check_field("processed_mode", want.processed_mode, record_bus.processed_mode);
          check_field("last_record", want.last_record, record_bus.last_record);
        end
      end
      record_bus.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding",
               cycle_count, pending_readings.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_HEADER:     cfg_header     = val;
      CFG_TERMINATOR: cfg_terminator = val;
      CFG_RAW_CMD:    cfg_raw        = val;
      CFG_PROC_CMD:   cfg_proc       = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] term,
                                input logic [7:0] raw, input logic [7:0] proc);
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_TERMINATOR, term);
    write_reg(CFG_RAW_CMD, raw);
    write_reg(CFG_PROC_CMD, proc);
  endtask

  // hold the sender until the block has drained, then let it settle
  task automatic drain_block();
    while (pending_bytes.size() > 0 || byte_bus.valid || pending_readings.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_count++;
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == cfg_header || b == cfg_terminator);
    return b;
  endfunction

  task automatic queue_record();
    logic [7:0] idb;
    logic [7:0] hib;
    logic [7:0] lob;
    idb = payload_byte();
    hib = payload_byte();
    lob = payload_byte();
    push_byte(idb);
    push_byte(hib);
    push_byte(lob);
    if ($urandom_range(9) < 7) push_byte((idb ^ hib ^ lob) & DATA_MASK);
    else push_byte(payload_byte());
  endtask

  task automatic queue_frame();
    int unsigned pick;
    int unsigned sel;
    int unsigned nrec;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 8) begin
      // line noise, ignored outside a frame unless it hits a header
      repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(255)));
    end else begin
      push_byte(cfg_header);
      if (sel < 45) push_byte(cfg_raw);
      else if (sel < 90) push_byte(cfg_proc);
      else if (sel < 95) push_byte(cfg_terminator);
      else push_byte(payload_byte());
      if (pick < 16) begin
        // near or past the frame size: full store, trailing partial, or overflow drop
        repeat ($urandom_range(60, 68)) push_byte(payload_byte());
        push_byte(cfg_terminator);
      end else begin
        nrec = ($urandom_range(9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
        repeat (nrec) queue_record();
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) push_byte(payload_byte());
        // a few frames are left open and get restarted by the next header
        if (pick >= 24) push_byte(cfg_terminator);
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    queued_count = 0;
    while (queued_count < target) queue_frame();
    drain_block();
  endtask

  initial begin
    byte_bus.valid   = 1'b0;
    byte_bus.rx_byte = '0;
    record_bus.ready = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle bytes, raw and processed frames at field extremes,
    // trailing partial record, terminator in the command slot
    push_byte(8'h00);
    push_byte(cfg_terminator);
    push_byte(cfg_header);
    push_byte(cfg_raw);
    push_byte(8'h7f);
    push_byte(8'hfd);
    push_byte(8'h80);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(cfg_terminator);
    push_byte(cfg_header);
    push_byte(cfg_proc);
    push_byte(8'he0);
    push_byte(8'h7f);
    push_byte(8'h7f);
    push_byte(8'h60);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(cfg_terminator);
    push_byte(cfg_header);
    push_byte(cfg_terminator);
    drain_block();

    // both commands equal, low header, high terminator
    apply_settings(8'h00, 8'hff, 8'h80, 8'h80);
    run_random(80);
    // header and terminator equal: header wins, frames never close
    apply_settings(8'h5a, 8'h5a, 8'h01, 8'hfe);
    run_random(30);
    // terminator doubles as the raw command
    apply_settings(8'h7e, 8'h7d, 8'h7d, 8'h00);
    run_random(70);
    apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(60);
    // reset values again, with no idling on either side
    apply_settings(HEADER_RST, TERMINATOR_RST, RAW_CMD_RST, PROC_CMD_RST);
    calm = 1'b1;
    run_random(140);
    calm = 1'b0;

    $display("covered %0d bytes over 6 register settings: %0d frames emitted records,",
             bytes_taken, frames_emitted);
    $display("%0d frames dropped on overflow, %0d records checked", frames_dropped,
             records_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/sfrd_pkg.sv
src/sfrd_if.sv
src/sfrd_datapath.sv
src/sfrd_ctrl.sv
src/sensor_frame_record_decoder_unit.sv
tb/sv/testbench.sv
